[design/isometric_project_with_bounds_core_defines.svh]
// Assertion macros shared by the RTL of the isometric projection core.
// Each macro expects a clock named i_clk and a synchronous active-low reset
// named i_rst_n in the module that uses it.
`ifndef ISOMETRIC_PROJECT_WITH_BOUNDS_CORE_DEFINES_SVH
`define ISOMETRIC_PROJECT_WITH_BOUNDS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPWB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPWB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/ipwb_pkg.sv]
package ipwb_pkg;

    localparam int FIELD_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int PROJ_SHIFT  = 9;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 112;

    // Widths of the exact intermediate values.
    localparam int CX_W = FIELD_W + 1;   // point plus offset
    localparam int CZ_W = FIELD_W + 2;   // negated sum
    localparam int PX_W = 24;            // (cx + cz) * 24
    localparam int PY_W = 25;            // (cx - cz) * 12 - 30 * cy
    localparam int DZ_W = 20;            // cz - cx - cy

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd4;

    // Values an empty bounding box starts from.
    localparam logic signed [FIELD_W-1:0] BOX_LOW_INIT  = 16'sd32767;
    localparam logic signed [FIELD_W-1:0] BOX_HIGH_INIT = -16'sd32767;

    typedef logic signed [FIELD_W-1:0] t_field;

    typedef struct packed {
        logic signed [CX_W-1:0] cx;
        logic signed [CX_W-1:0] cy;
        logic signed [CZ_W-1:0] cz;
        logic                   first;
    } t_point;

    typedef struct packed {
        t_field centre_x;
        t_field centre_y;
    } t_centre;

    typedef struct packed {
        t_field sx;
        t_field sy;
        t_field dz;
    } t_proj;

    typedef struct packed {
        t_field left;
        t_field right;
        t_field top;
        t_field bottom;
    } t_box;

endpackage

[design/ipwb_front.sv]
module ipwb_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ipwb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ipwb_pkg::FIELD_W-1:0]     i_cfg_data,
    input  logic                             i_load,
    input  ipwb_pkg::t_field                 i_x,
    input  ipwb_pkg::t_field                 i_y,
    input  ipwb_pkg::t_field                 i_z,
    input  logic                             i_first,
    output ipwb_pkg::t_point                 o_point,
    output ipwb_pkg::t_centre                o_centre
);
    import ipwb_pkg::*;

    t_field r_off_x;
    t_field r_off_y;
    t_field r_off_z;
    t_field r_centre_x;
    t_field r_centre_y;
    t_point r_point;
    t_point n_point;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x    <= '0;
            r_off_y    <= '0;
            r_off_z    <= '0;
            r_centre_x <= '0;
            r_centre_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFSET_X: r_off_x    <= i_cfg_data;
                REG_OFFSET_Y: r_off_y    <= i_cfg_data;
                REG_OFFSET_Z: r_off_z    <= i_cfg_data;
                REG_CENTRE_X: r_centre_x <= i_cfg_data;
                REG_CENTRE_Y: r_centre_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Camera offsets are applied on the way into the input register.
    always_comb begin
        n_point.cx    = CX_W'(i_x) + CX_W'(r_off_x);
        n_point.cy    = CX_W'(i_y) + CX_W'(r_off_y);
        n_point.cz    = -(CZ_W'(i_z) + CZ_W'(r_off_z));
        n_point.first = i_first;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_point <= n_point;
        end
    end

    assign o_point           = r_point;
    assign o_centre.centre_x = r_centre_x;
    assign o_centre.centre_y = r_centre_y;

endmodule

[design/ipwb_proj.sv]
module ipwb_proj (
    input  ipwb_pkg::t_point  i_point,
    input  ipwb_pkg::t_centre i_centre,
    output ipwb_pkg::t_proj   o_proj
);
    import ipwb_pkg::*;

    logic signed [PX_W-1:0] sum_xz;
    logic signed [PX_W-1:0] prod_x;
    logic signed [PX_W-1:0] shift_x;
    logic signed [PY_W-1:0] diff_xz;
    logic signed [PY_W-1:0] ext_y;
    logic signed [PY_W-1:0] prod_y;
    logic signed [PY_W-1:0] shift_y;
    logic signed [DZ_W-1:0] depth_w;

    // Constant multiplies are built from shifted adds.
    always_comb begin
        sum_xz  = PX_W'(i_point.cx) + PX_W'(i_point.cz);
        prod_x  = (sum_xz <<< 4) + (sum_xz <<< 3);
        shift_x = prod_x >>> PROJ_SHIFT;

        diff_xz = PY_W'(i_point.cx) - PY_W'(i_point.cz);
        ext_y   = PY_W'(i_point.cy);
        prod_y  = (diff_xz <<< 3) + (diff_xz <<< 2) - ((ext_y <<< 5) - (ext_y <<< 1));
        shift_y = prod_y >>> PROJ_SHIFT;

        depth_w = DZ_W'(i_point.cz) - DZ_W'(i_point.cx) - DZ_W'(i_point.cy);

        // Wrapping to 16 bits commutes with adding the centre.
        o_proj.sx = shift_x[FIELD_W-1:0] + i_centre.centre_x;
        o_proj.sy = shift_y[FIELD_W-1:0] + i_centre.centre_y;
        o_proj.dz = depth_w[FIELD_W-1:0];
    end

endmodule

[design/ipwb_box.sv]
module ipwb_box (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_update,
    input  logic             i_first,
    input  ipwb_pkg::t_field i_sx,
    input  ipwb_pkg::t_field i_sy,
    output ipwb_pkg::t_box   o_box,
    output ipwb_pkg::t_box   o_state
);
    import ipwb_pkg::*;

    t_box r_box;
    t_box base;
    t_box n_box;

    // A first point of a model starts from an empty box.
    always_comb begin
        if (i_first) begin
            base.left   = BOX_LOW_INIT;
            base.right  = BOX_HIGH_INIT;
            base.top    = BOX_LOW_INIT;
            base.bottom = BOX_HIGH_INIT;
        end else begin
            base = r_box;
        end
        n_box.left   = (i_sx < base.left)   ? i_sx : base.left;
        n_box.right  = (i_sx > base.right)  ? i_sx : base.right;
        n_box.top    = (i_sy < base.top)    ? i_sy : base.top;
        n_box.bottom = (i_sy > base.bottom) ? i_sy : base.bottom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.left   <= BOX_LOW_INIT;
            r_box.right  <= BOX_HIGH_INIT;
            r_box.top    <= BOX_LOW_INIT;
            r_box.bottom <= BOX_HIGH_INIT;
        end else if (i_update) begin
            r_box <= n_box;
        end
    end

    assign o_box   = n_box;
    assign o_state = r_box;

endmodule

[design/isometric_project_with_bounds_core.sv]
// Channel   Direction  Word                                      Side band
// s_axis    in         point_x, point_y, point_z (48 bits)       first_of_model
// m_axis    out        screen_x, screen_y, depth, box (112 bits) none
// i_cfg     in         index 0..4, 16-bit data                   none
//
// A word waits in the input register, where the camera offsets are already
// applied, and is projected and merged into the box on its way to the result
// register. One word is taken per cycle unless the result output stalls; the
// box update in front of the result register feeds back through the box state.
// Reset clears both valid flags, the configuration registers and the box.
// A stalled result holds the result register, and the input register keeps
// accepting until it is also full.
`include "isometric_project_with_bounds_core_defines.svh"

module isometric_project_with_bounds_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [ipwb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ipwb_pkg::FIELD_W-1:0]        i_cfg_data,
    // Input words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: point_x [15:0], point_y [31:16], point_z [47:32]
    input  logic [ipwb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: first_of_model [0]
    input  logic                                s_axis_tuser,
    // Result words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: screen_x [15:0], screen_y [31:16], depth [47:32],
    //        box_left [63:48], box_right [79:64], box_top [95:80],
    //        box_bottom [111:96]
    output logic [ipwb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import ipwb_pkg::*;

    logic    r_s1_vld;
    logic    n_s1_vld;
    logic    r_out_vld;
    logic    n_out_vld;
    logic    in_load;
    logic    out_load;
    t_point  point;
    t_centre centre;
    t_proj   proj;
    t_box    box_next;
    t_box    box_state;
    t_proj   r_res_proj;
    t_box    r_res_box;

    // The result register moves when the input register holds a word and it is empty
    // or being drained; the input register is ready whenever its word goes on or it is empty.
    assign out_load      = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (in_load) begin
            n_s1_vld = 1'b1;
        end else if (out_load) begin
            n_s1_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    ipwb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_load     (in_load),
        .i_x        (s_axis_tdata[15:0]),
        .i_y        (s_axis_tdata[31:16]),
        .i_z        (s_axis_tdata[47:32]),
        .i_first    (s_axis_tuser),
        .o_point    (point),
        .o_centre   (centre)
    );

    ipwb_proj u_proj (
        .i_point  (point),
        .i_centre (centre),
        .o_proj   (proj)
    );

    // The box state advances together with the result register, so each
    // result carries the box that includes its own point.
    ipwb_box u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (out_load),
        .i_first  (point.first),
        .i_sx     (proj.sx),
        .i_sy     (proj.sy),
        .o_box    (box_next),
        .o_state  (box_state)
    );

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res_proj <= proj;
            r_res_box  <= box_next;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_res_box.bottom, r_res_box.top, r_res_box.right,
                            r_res_box.left, r_res_proj.dz, r_res_proj.sy,
                            r_res_proj.sx};

    // Every delivered point lies inside the box reported with it.
    `IPWB_ASSERT_SAME(a_point_in_box_x, r_out_vld,
        (r_res_box.left <= r_res_proj.sx) && (r_res_proj.sx <= r_res_box.right),
        "screen x outside reported box")
    `IPWB_ASSERT_SAME(a_point_in_box_y, r_out_vld,
        (r_res_box.top <= r_res_proj.sy) && (r_res_proj.sy <= r_res_box.bottom),
        "screen y outside reported box")
    // The running box and the reported box agree after each result load.
    `IPWB_ASSERT_NEXT(a_box_tracks_result, out_load,
        box_state == r_res_box, "box state differs from reported box")
    // The first point of a model is the low corner of its box. The high
    // corner starts one above the most negative value, so it is not checked.
    `IPWB_ASSERT_NEXT(a_first_point_box, out_load && point.first,
        (r_res_box.left == r_res_proj.sx) && (r_res_box.top == r_res_proj.sy),
        "first point of model did not restart box")

endmodule
